[hw/rtl/tdpt_pkg.sv]
// Shared control and status types for the trial-division prime tester.
package tdpt_pkg;

  // Command from the sequencer to the serial divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Status from the serial divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_stat_t;

  // Smallest candidate divisor.
  localparam int unsigned FIRST_DIVISOR = 2;

endpackage

[hw/rtl/tdpt_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module tdpt_div #(
  parameter int VALUE_WIDTH = 32,
  parameter int DIV_WIDTH   = 17
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tdpt_pkg::div_ctrl_t      ctrl,
  input  logic [VALUE_WIDTH-1:0]   dividend,
  input  logic [DIV_WIDTH-1:0]     divisor,
  output logic [VALUE_WIDTH-1:0]   quotient,
  output tdpt_pkg::div_stat_t      stat
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] shreg;
  logic [DIV_WIDTH-1:0]   rem;
  logic [DIV_WIDTH-1:0]   dvs;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   done;

  logic [DIV_WIDTH:0]     trial;
  logic [DIV_WIDTH:0]     diff;
  logic                   qbit;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem, shreg[VALUE_WIDTH-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
  end

  // Control: bit counter, busy and done flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[VALUE_WIDTH-2:0], qbit};
      rem   <= qbit ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
    end
  end

  assign quotient      = shreg;
  assign stat.busy     = busy;
  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

[hw/rtl/trial_division_prime_test_core.sv]
// Top level of the trial-division prime tester: sequencer and result register.
//
// Usage: the input channel (in_valid, in_stall, value) takes one signed
// integer per transaction; the output channel (out_valid, out_stall,
// is_prime) returns one bit per transaction, 1 when the value is prime.
// Values below two, negative values included, give 0 without any division.
// Otherwise divisors d = 2, 3, ... are tried; each trial starts the bit-serial
// divider, waits for it to finish and then evaluates the remainder, and
// the quotient of the same division gives the bound d <= value / d.
// One value is worked on at a time; in_stall is high while a test runs or
// while a finished result waits for the output register.
// The output register holds its result while out_stall is high; the next
// value can be accepted as soon as the current result is in that register.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
module trial_division_prime_test_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   is_prime
);

  localparam int DW = VALUE_WIDTH / 2 + 1;
  localparam int SW = 3;

  localparam logic [SW-1:0] S_IDLE  = 3'd0;
  localparam logic [SW-1:0] S_CHECK = 3'd1;
  localparam logic [SW-1:0] S_DIV   = 3'd2;
  localparam logic [SW-1:0] S_EVAL  = 3'd3;
  localparam logic [SW-1:0] S_DONE  = 3'd4;

  logic [SW-1:0]          state, state_next;
  logic [VALUE_WIDTH-1:0] v;
  logic [DW-1:0]          d, d_next;
  logic                   res, res_next;

  tdpt_pkg::div_ctrl_t    ctrl;
  tdpt_pkg::div_stat_t    stat;
  logic [VALUE_WIDTH-1:0] quot;

  logic                   trivial;
  logic                   past_bound;
  logic                   out_free;

  tdpt_div #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIV_WIDTH   (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .dividend (v),
    .divisor  (d_next),
    .quotient (quot),
    .stat     (stat)
  );

  // Negative, zero and one are never prime.
  assign trivial    = v[VALUE_WIDTH-1] || (v < VALUE_WIDTH'(2));
  // Loop ends once d exceeds value / d.
  assign past_bound = {{(VALUE_WIDTH-DW){1'b0}}, d} > quot;
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE);

  // Sequencer next-state logic.
  always_comb begin
    state_next = state;
    d_next     = d;
    res_next   = res;
    ctrl.start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (trivial) begin
          res_next   = 1'b0;
          state_next = S_DONE;
        end else begin
          d_next     = DW'(tdpt_pkg::FIRST_DIVISOR);
          ctrl.start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (past_bound) begin
          res_next   = 1'b1;
          state_next = S_DONE;
        end else if (stat.rem_zero) begin
          res_next   = 1'b0;
          state_next = S_DONE;
        end else begin
          d_next     = d + DW'(1);
          ctrl.start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    d   <= d_next;
    res <= res_next;
    if (state == S_IDLE && in_valid) begin
      v <= value;
    end
  end

  // Output register: loads from the sequencer, empties on a transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      is_prime <= res;
    end
  end

  // The divider only reports completion to a waiting sequencer.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  // A new division never starts on top of one in progress.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !stat.busy)
    else $error("divider started while busy");

  // A fresh result appears only after the sequencer finished a test.
  a_rose_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result appeared without a finished test");

  // Every evaluated divisor is at least two.
  a_div_min: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> d >= DW'(tdpt_pkg::FIRST_DIVISOR))
    else $error("trial divisor below two");

endmodule
